@@ rtl/lcdsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcdsw_pkg;

  typedef enum logic [2:0] {
    REQ_STORE      = 3'd0,
    REQ_FULL       = 3'd1,
    REQ_PARTIAL    = 3'd2,
    REQ_COMMAND    = 3'd3,
    REQ_DIRECT     = 3'd4,
    REQ_INVALIDATE = 3'd5
  } req_e;

  // Wire bits handed out per chunk.
  localparam int CHUNK_WIDTH = 16;

  localparam logic [2:0] HDR_WRITE = 3'b101;
  localparam logic [2:0] HDR_CMD   = 3'b100;

  // Frame lengths in wire bits.
  localparam int WR_HDR_LEN    = 9;
  localparam int CMD_FRAME_LEN = 12;
  localparam int DIR_FRAME_LEN = 13;
  localparam int NIB_LEN       = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request fields
    logic store;      // write shadow entry
    logic inval;      // set all stale marks
    logic scan_step;  // examine one entry
    logic hdr_load;   // load write header into the shift buffer
    logic cmd_load;   // load command frame into the shift buffer
    logic dir_load;   // load direct write frame
    logic ent_push;   // append one shadow nibble, commit entry
    logic emit;       // emit one full chunk
    logic emit_fin;   // emit the closing chunk of the frame
  } ctl_t;

  typedef struct packed {
    logic part_ok;
    logic scan_done;
    logic found;
    logic span_done;
    logic buf_full;
    logic buf_last;
    logic buf_empty;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/lcdsw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lcdsw_ctrl
  import lcdsw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] req_type_i,
  input  wire sts_t       sts_i,
  output ctl_t            ctl_o,
  output logic            busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SIDE, ST_SCAN, ST_HDR, ST_FILL, ST_FLUSH
  } state_e;

  state_e     state_q;
  logic [2:0] kind_q;

  always_comb begin
    ctl_o = '0;
    case (state_q)
      ST_IDLE: ctl_o.load = start_i;
      ST_SIDE: begin
        case (kind_q)
          REQ_STORE:      ctl_o.store = 1'b1;
          REQ_INVALIDATE: ctl_o.inval = 1'b1;
          REQ_COMMAND:    ctl_o.cmd_load = 1'b1;
          REQ_DIRECT:     ctl_o.dir_load = 1'b1;
          default: ;
        endcase
      end
      ST_SCAN: ctl_o.scan_step = 1'b1;
      ST_HDR:  ctl_o.hdr_load = 1'b1;
      ST_FILL: begin
        // A full buffer is drained before the next nibble goes in.
        if (sts_i.buf_full) ctl_o.emit = 1'b1;
        else ctl_o.ent_push = 1'b1;
      end
      ST_FLUSH: begin
        if (!sts_i.buf_empty) begin
          if (sts_i.buf_last) ctl_o.emit_fin = 1'b1;
          else ctl_o.emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q <= 3'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            kind_q <= req_type_i;
            case (req_type_i)
              REQ_FULL:    state_q <= ST_SCAN;
              REQ_PARTIAL: state_q <= sts_i.part_ok ? ST_SCAN : ST_IDLE;
              default:     state_q <= ST_SIDE;
            endcase
          end
        end
        ST_SIDE: state_q <= ST_FLUSH;
        ST_SCAN: begin
          if (sts_i.scan_done) state_q <= sts_i.found ? ST_HDR : ST_IDLE;
        end
        ST_HDR: state_q <= ST_FILL;
        ST_FILL: begin
          if (!sts_i.buf_full && sts_i.span_done) state_q <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (sts_i.buf_empty || sts_i.buf_last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/lcd_segment_ram_serial_writer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-wire segment LCD writer. A request is taken at a rising edge where
// start_i is high and busy_o is low; every result chunk is on the outputs for
// exactly one cycle with valid_o high, and the receiver cannot stall it, so it
// must take each chunk as it comes. Store, invalidate and unknown requests
// pass through the side and flush states and send no chunk. Command and
// direct write send a single chunk, strobed in the cycle right after busy_o
// falls. A partial commit with a reversed range or an end at or past the RAM
// is dropped without raising busy_o. A commit first scans its range one entry
// per cycle; when something is dirty it loads the header, appends one nibble
// per entry from the first to the last dirty one (every entry for a full
// commit), draining each full chunk before the next nibble, and ends with one
// or two closing chunks. A full commit sends all 64 entries, and its closing
// chunk is strobed in the cycle after busy_o falls. The one-entry-per-cycle
// scan and fill over the shadow RAM set the rate, the fill held while a chunk drains.
module lcd_segment_ram_serial_writer_top
  import lcdsw_pkg::*;
#(
  parameter int RAM_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [5:0]  addr_i,
  input  wire logic [3:0]  nibble_i,
  input  wire logic [7:0]  range_start_i,
  input  wire logic [7:0]  range_end_i,
  input  wire logic [7:0]  command_i,
  output logic             valid_o,
  output logic [15:0]      chunk_bits_o,
  output logic [4:0]       chunk_len_o,
  output logic             frame_end_o,
  output logic             last_o
);

  localparam int AW = $clog2(RAM_DEPTH);
  // A nibble is appended only while fewer than CHUNK_WIDTH bits wait.
  localparam int BW = CHUNK_WIDTH + NIB_LEN;
  localparam int LW = $clog2(BW + 1);

  ctl_t ctl;
  sts_t sts;

  // Fields of the request in progress.
  logic [2:0]    req_q;
  logic [5:0]    addr_q;
  logic [3:0]    nib_q;
  logic [AW-1:0] re_q;
  logic [7:0]    cmd_q;

  // Shadow and last-sent nibbles live in RAMs with a registered read port.
  // Entries never stored read as zero through the written flags; last-sent
  // contents only matter once an entry is no longer stale, and clearing the
  // stale mark always writes last-sent in the same cycle.
  logic [3:0]           shadow_q [RAM_DEPTH];
  logic [3:0]           sent_q   [RAM_DEPTH];
  logic [3:0]           shadow_rd_q;
  logic [3:0]           sent_rd_q;
  logic [RAM_DEPTH-1:0] written_q;
  logic [RAM_DEPTH-1:0] stale_q;
  logic                 wr_rd_q;
  logic                 stale_rd_q;

  // Scan and fill bookkeeping.
  logic [AW-1:0] idx_q, idx_d, first_q, lastd_q;
  logic          found_q;
  logic [BW-1:0] buf_q;
  logic [LW-1:0] cnt_q;

  logic          addr_ok;
  logic [3:0]    shadow_val;
  logic          dirty;
  logic [AW-1:0] scan_end;
  logic          scan_done, span_done;
  logic [5:0]    hdr_addr;
  logic [BW-1:0] cmd_frame, dir_frame, hdr_frame;

  lcdsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .busy_o     (busy_o)
  );

  assign addr_ok    = (32'(addr_q) < 32'(RAM_DEPTH));
  // The read registers always hold the entry at idx_q.
  assign shadow_val = wr_rd_q ? shadow_rd_q : 4'h0;
  assign dirty      = stale_rd_q || (shadow_val != sent_rd_q);
  assign scan_end   = (req_q == REQ_FULL) ? AW'(RAM_DEPTH - 1) : re_q;
  assign scan_done  = (idx_q == scan_end);
  assign span_done  = (idx_q == lastd_q);
  assign hdr_addr   = (req_q == REQ_FULL) ? 6'd0 : 6'(first_q);

  always_comb begin
    sts.part_ok   = (range_start_i <= range_end_i) && (range_end_i < 8'(RAM_DEPTH));
    sts.scan_done = scan_done;
    sts.found     = found_q || dirty;
    sts.span_done = span_done;
    sts.buf_full  = (cnt_q >= LW'(CHUNK_WIDTH));
    sts.buf_last  = (cnt_q <= LW'(CHUNK_WIDTH));
    sts.buf_empty = (cnt_q == '0);
  end

  // The read address runs one step ahead so the data lines up with idx_q.
  always_comb begin
    idx_d = idx_q;
    if (ctl.load) begin
      idx_d = (req_type_i == REQ_PARTIAL) ? range_start_i[AW-1:0] : '0;
    end else if (ctl.scan_step && !scan_done) begin
      idx_d = idx_q + 1'b1;
    end else if (ctl.hdr_load) begin
      idx_d = (req_q == REQ_FULL) ? '0 : first_q;
    end else if (ctl.ent_push && !span_done) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // Frames are laid out with bit 0 on the wire first; the start bits and
  // address and command fields go MSB first, nibbles LSB first.
  always_comb begin
    cmd_frame = '0;
    dir_frame = '0;
    hdr_frame = '0;
    for (int i = 0; i < 3; i++) begin
      cmd_frame[i] = HDR_CMD[2-i];
      dir_frame[i] = HDR_WRITE[2-i];
      hdr_frame[i] = HDR_WRITE[2-i];
    end
    for (int i = 0; i < 8; i++) cmd_frame[3+i] = cmd_q[7-i];
    for (int i = 0; i < 6; i++) begin
      dir_frame[3+i] = addr_q[5-i];
      hdr_frame[3+i] = hdr_addr[5-i];
    end
    dir_frame[12:9] = nib_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      req_q <= req_type_i;
      addr_q <= addr_i;
      nib_q <= nibble_i;
      re_q <= range_end_i[AW-1:0];
      cmd_q <= command_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.store && addr_ok) shadow_q[addr_q[AW-1:0]] <= nib_q;
    if (ctl.ent_push) sent_q[idx_q] <= shadow_val;
    shadow_rd_q <= shadow_q[idx_d];
    sent_rd_q <= sent_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      stale_q <= '1;
      wr_rd_q <= 1'b0;
      stale_rd_q <= 1'b0;
      idx_q <= '0;
      first_q <= '0;
      lastd_q <= '0;
      found_q <= 1'b0;
      buf_q <= '0;
      cnt_q <= '0;
      valid_o <= 1'b0;
      chunk_bits_o <= '0;
      chunk_len_o <= '0;
      frame_end_o <= 1'b0;
      last_o <= 1'b0;
    end else begin
      idx_q <= idx_d;
      wr_rd_q <= written_q[idx_d];
      stale_rd_q <= stale_q[idx_d];

      if (ctl.store && addr_ok) written_q[addr_q[AW-1:0]] <= 1'b1;

      if (ctl.inval) stale_q <= '1;
      else if (ctl.ent_push) stale_q[idx_q] <= 1'b0;

      if (ctl.load) found_q <= 1'b0;
      else if (ctl.scan_step && dirty) found_q <= 1'b1;

      if (ctl.scan_step && dirty && !found_q) first_q <= idx_q;

      if (ctl.scan_step && dirty) lastd_q <= idx_q;
      else if (ctl.hdr_load && req_q == REQ_FULL) lastd_q <= AW'(RAM_DEPTH - 1);

      if (ctl.load) begin
        buf_q <= '0;
        cnt_q <= '0;
      end else if (ctl.cmd_load) begin
        buf_q <= cmd_frame;
        cnt_q <= LW'(CMD_FRAME_LEN);
      end else if (ctl.dir_load) begin
        buf_q <= dir_frame;
        cnt_q <= LW'(DIR_FRAME_LEN);
      end else if (ctl.hdr_load) begin
        buf_q <= hdr_frame;
        cnt_q <= LW'(WR_HDR_LEN);
      end else if (ctl.ent_push) begin
        buf_q[cnt_q +: 4] <= shadow_val;
        cnt_q <= cnt_q + LW'(NIB_LEN);
      end else if (ctl.emit) begin
        buf_q <= buf_q >> CHUNK_WIDTH;
        cnt_q <= cnt_q - LW'(CHUNK_WIDTH);
      end else if (ctl.emit_fin) begin
        cnt_q <= '0;
      end

      // Bits above the fill count are zero whenever a chunk is emitted, so chunks need no mask.
      valid_o <= ctl.emit || ctl.emit_fin;
      frame_end_o <= ctl.emit_fin;
      last_o <= ctl.emit_fin;
      if (ctl.emit || ctl.emit_fin) begin
        chunk_bits_o <= buf_q[CHUNK_WIDTH-1:0];
        chunk_len_o <= ctl.emit_fin ? 5'(cnt_q) : 5'(CHUNK_WIDTH);
      end
    end
  end

endmodule

`default_nettype wire
